// File: sv/assert_macros.svh
// Assertion shorthands shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lcmc_pkg.sv
`default_nettype none

package lcmc_pkg;

    localparam int CFG_W    = 11;
    localparam int CFGI_W   = 2;
    localparam int BLK_W    = 10;
    localparam int TILE_W   = 10;
    localparam int PROD_W   = 21;
    localparam int SUM_W    = 22;
    localparam int EVK_W    = 10;
    localparam int CNT_W    = 48;

    // Largest occupancy the capacity register can ask for.
    localparam int CAP_LIMIT = (2 ** CFG_W) - 1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CFGI_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFGI_W-1:0] REG_TILES    = 2'd1;
    localparam logic [CFGI_W-1:0] REG_BLOCKS   = 2'd2;

    localparam logic [CFG_W-1:0] CAPACITY_RST = 11'd16;
    localparam logic [CFG_W-1:0] TILES_RST    = 11'd1;
    localparam logic [CFG_W-1:0] BLOCKS_RST   = 11'd1;

    // Control flags of one reference as it walks the cell chain.
    typedef struct packed {
        logic valid;
        logic proc;
        logic carry_v;
        logic hit;
        logic ev_v;
        logic err;
        logic fin;
    } tok_t;

    // One finished result beat.
    typedef struct packed {
        logic             hit;
        logic             miss;
        logic             ev_v;
        logic [EVK_W-1:0] ev_key;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] ref_total;
        logic             err;
        logic             done;
    } res_t;

endpackage

`default_nettype wire

// File: sv/lcmc_front.sv
`default_nettype none

module lcmc_front
    import lcmc_pkg::*;
#(
    parameter int KEY_SPACE = 1024,
    parameter int KEY_W     = 10
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire logic [BLK_W-1:0]  block,
    input  wire logic [TILE_W-1:0] tile,
    input  wire logic              active,
    input  wire logic              final_item,
    input  wire logic [CFG_W-1:0]  capacity,
    input  wire logic [CFG_W-1:0]  tiles_per_block,
    input  wire logic [CFG_W-1:0]  block_count,
    output tok_t                   tok_out,
    output logic [KEY_W-1:0]       key_out
);

    // stage A: products
    logic              a_valid_reg;
    logic              a_act_reg;
    logic              a_fin_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic [TILE_W-1:0] a_tile_reg;
    logic [SUM_W-1:0]  span_reg;

    // stage B: key, range check
    tok_t              tok_reg;
    tok_t              tok_next;
    logic [KEY_W-1:0]  key_reg;
    logic [SUM_W-1:0]  key_full;
    logic              cfg_bad;
    logic              err;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            tok_reg     <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= SUM_W'(tiles_per_block) * SUM_W'(block_count);
        if (adv)
        begin
            a_act_reg  <= active;
            a_fin_reg  <= final_item;
            a_prod_reg <= PROD_W'(block) * PROD_W'(tiles_per_block);
            a_tile_reg <= tile;
            key_reg    <= KEY_W'(key_full);
        end
    end

    always_comb
    begin
        key_full = SUM_W'(a_prod_reg) + SUM_W'(a_tile_reg);
        cfg_bad  = (capacity == '0) || (span_reg == '0) ||
                   (span_reg > SUM_W'(KEY_SPACE));
        err      = cfg_bad || (a_act_reg && (key_full >= span_reg));

        tok_next         = '0;
        tok_next.valid   = a_valid_reg;
        tok_next.proc    = a_act_reg && !err;
        tok_next.carry_v = a_act_reg && !err;
        tok_next.err     = err;
        tok_next.fin     = a_fin_reg;
    end

    assign tok_out = tok_reg;
    assign key_out = key_reg;

endmodule

`default_nettype wire

// File: sv/lcmc_cell.sv
`default_nettype none

`include "assert_macros.svh"

module lcmc_cell
    import lcmc_pkg::*;
#(
    parameter int KEY_W = 10,
    parameter int IDX   = 0
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             adv,
    input  wire logic [CFG_W-1:0] capacity,
    input  wire tok_t             tok_in,
    input  wire logic [KEY_W-1:0] key_in,
    input  wire logic [KEY_W-1:0] carry_in,
    output tok_t                  tok_out,
    output logic [KEY_W-1:0]      key_out,
    output logic [KEY_W-1:0]      carry_out
);

    localparam logic [CFG_W:0] IDX_V = (CFG_W+1)'(IDX);

    logic             ent_v_reg;
    logic             ent_v_next;
    logic [KEY_W-1:0] ent_key_reg;
    logic [KEY_W-1:0] ent_key_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] carry_reg;
    logic [KEY_W-1:0] carry_next;
    logic             work;
    logic             evict_here;

    assign work       = tok_in.valid && tok_in.proc && tok_in.carry_v;
    assign evict_here = ({1'b0, capacity} <= IDX_V);

    always_comb
    begin
        tok_next     = tok_in;
        carry_next   = carry_in;
        ent_v_next   = ent_v_reg;
        ent_key_next = ent_key_reg;
        if (work)
        begin
            if (ent_v_reg)
            begin
                // take the carried key, pass the old one on unless it is the hit
                ent_key_next = carry_in;
                if (ent_key_reg == key_in)
                begin
                    tok_next.carry_v = 1'b0;
                    tok_next.hit     = 1'b1;
                end
                else
                begin
                    carry_next = ent_key_reg;
                end
            end
            else if (evict_here)
            begin
                // drop the old least recent key: it rides on as the victim
                tok_next.carry_v = 1'b0;
                tok_next.ev_v    = 1'b1;
            end
            else
            begin
                ent_v_next       = 1'b1;
                ent_key_next     = carry_in;
                tok_next.carry_v = 1'b0;
            end
        end
        if (tok_in.valid && tok_in.fin)
        begin
            ent_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_v_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            ent_v_reg <= ent_v_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_key_reg <= ent_key_next;
            key_reg     <= key_in;
            carry_reg   <= carry_next;
        end
    end

    assign tok_out   = tok_reg;
    assign key_out   = key_reg;
    assign carry_out = carry_reg;

    `ASSERT_CLK(a_cell_hit_ev, !(tok_out.valid && tok_out.hit && tok_out.ev_v), "hit with eviction")
    `ASSERT_NXT(a_cell_resolve, work && !ent_v_reg && adv, !tok_out.carry_v, "carry passed empty cell")

endmodule

`default_nettype wire

// File: sv/lcmc_back.sv
`default_nettype none

`include "assert_macros.svh"

module lcmc_back
    import lcmc_pkg::*;
#(
    parameter int KEY_W = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tok_t             tok_in,
    input  wire logic [KEY_W-1:0] carry_in,
    input  wire logic             out_ready,
    output logic                  adv,
    output logic                  out_valid,
    output res_t                  res_out
);

    logic [CNT_W-1:0] miss_total_reg;
    logic [CNT_W-1:0] miss_total_next;
    logic [CNT_W-1:0] ref_total_reg;
    logic [CNT_W-1:0] ref_total_next;
    res_t             buf_mem [2];
    res_t             res_new;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;
    logic             is_miss;
    logic             is_ev;

    assign adv       = (count_reg != 2'd2);
    assign push      = tok_in.valid && adv;
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        is_miss = tok_in.proc && !tok_in.hit;
        // a carry still held past the last cell is the victim of a full chain
        is_ev   = tok_in.ev_v || tok_in.carry_v;

        miss_total_next = miss_total_reg;
        if (is_miss && (miss_total_reg != CNT_MAX))
        begin
            miss_total_next = miss_total_reg + 1'b1;
        end
        ref_total_next = ref_total_reg;
        if (tok_in.proc && (ref_total_reg != CNT_MAX))
        begin
            ref_total_next = ref_total_reg + 1'b1;
        end

        res_new            = '0;
        res_new.hit        = tok_in.hit;
        res_new.miss       = is_miss;
        res_new.ev_v       = is_ev;
        res_new.ev_key     = is_ev ? EVK_W'(carry_in) : '0;
        res_new.miss_total = miss_total_next;
        res_new.ref_total  = ref_total_next;
        res_new.err        = tok_in.err;
        res_new.done       = tok_in.fin;

        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_total_reg <= '0;
            ref_total_reg  <= '0;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg     <= !wr_ptr_reg;
                miss_total_reg <= tok_in.fin ? '0 : miss_total_next;
                ref_total_reg  <= tok_in.fin ? '0 : ref_total_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_mem[wr_ptr_reg] <= res_new;
        end
    end

    assign res_out = buf_mem[rd_ptr_reg];

    `ASSERT_IMP(a_back_totals, out_valid, res_out.miss_total <= res_out.ref_total, "misses above refs")
    `ASSERT_IMP(a_back_hitmiss, out_valid, !(res_out.hit && res_out.miss), "hit and miss")
    `ASSERT_IMP(a_back_err, out_valid && res_out.err, !res_out.hit && !res_out.miss && !res_out.ev_v, "error with effect")

endmodule

`default_nettype wire

// File: sv/lru_cache_miss_counter.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+---------------------------------------------
// in       | in_valid / in_ready    | block, tile, active, final_item
// out      | out_valid / out_ready  | hit, miss, evicted_valid, evicted_key,
//          |                        | miss_total, reference_total, error, done_res
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The pipe is two front stages, one stage per cell and one buffer stage; a new beat
// enters every cycle while the output buffer has room, so the sustained rate is one
// item per cycle, set by the cell chain advancing one cell per clock.
// Reset clears all cell valid bits, both totals and the output buffer at once.
// When the two-entry output buffer is full the whole chain holds; in_ready drops.
// cfg_ready is always high.
`default_nettype none

module lru_cache_miss_counter
    import lcmc_pkg::*;
#(
    parameter int KEY_SPACE = 1024
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,

    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BLK_W-1:0]  block,
    input  wire logic [TILE_W-1:0] tile,
    input  wire logic              active,
    input  wire logic              final_item,

    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   hit,
    output logic                   miss,
    output logic                   evicted_valid,
    output logic [EVK_W-1:0]       evicted_key,
    output logic [CNT_W-1:0]       miss_total,
    output logic [CNT_W-1:0]       reference_total,
    output logic                   error,
    output logic                   done_res
);

    // Key width covers every key below KEY_SPACE. The chain needs one cell per
    // resident key: never more than the key space, never more than the largest
    // capacity the register can hold.
    localparam int KEY_W  = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
    localparam int NCELLS = (KEY_SPACE < CAP_LIMIT) ? KEY_SPACE : CAP_LIMIT;

    logic [CFG_W-1:0] capacity_reg;
    logic [CFG_W-1:0] tiles_reg;
    logic [CFG_W-1:0] blocks_reg;
    logic             adv;
    res_t             res;

    // Token, request key and carried key at the input of each cell; the last
    // slot is what leaves the chain.
    tok_t             tok_a   [NCELLS+1];
    logic [KEY_W-1:0] key_a   [NCELLS+1];
    logic [KEY_W-1:0] carry_a [NCELLS+1];

    // Configuration: take every write at once; ignore indexes past the list.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
            tiles_reg    <= TILES_RST;
            blocks_reg   <= BLOCKS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CAPACITY: capacity_reg <= cfg_data;
                REG_TILES:    tiles_reg    <= cfg_data;
                REG_BLOCKS:   blocks_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Advance the whole pipe together while the output buffer has room.
    assign in_ready = adv;

    // Front: form the key, check the key space, flag bad configuration.
    lcmc_front #(
        .KEY_SPACE (KEY_SPACE),
        .KEY_W     (KEY_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .in_valid        (in_valid),
        .block           (block),
        .tile            (tile),
        .active          (active),
        .final_item      (final_item),
        .capacity        (capacity_reg),
        .tiles_per_block (tiles_reg),
        .block_count     (blocks_reg),
        .tok_out         (tok_a[0]),
        .key_out         (key_a[0])
    );

    // The new key enters cell 0 as the carried value: it lands at the most
    // recent end, and every older key it passes shifts one place deeper.
    assign carry_a[0] = key_a[0];

    // Recency stack: cell 0 holds the most recent key, valid cells are always a
    // contiguous run from cell 0, so the first empty cell a reference meets is
    // the occupancy. There a miss either settles the displaced least recent key
    // or, with occupancy at capacity, drops it as the victim. A final beat
    // clears each cell right after passing it, so the next stream starts empty.
    for (genvar i = 0; i < NCELLS; i++)
    begin : g_cell
        lcmc_cell #(
            .KEY_W (KEY_W),
            .IDX   (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .capacity  (capacity_reg),
            .tok_in    (tok_a[i]),
            .key_in    (key_a[i]),
            .carry_in  (carry_a[i]),
            .tok_out   (tok_a[i+1]),
            .key_out   (key_a[i+1]),
            .carry_out (carry_a[i+1])
        );
    end

    // Back: running totals in stream order and the two-entry output buffer.
    lcmc_back #(
        .KEY_W (KEY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_in    (tok_a[NCELLS]),
        .carry_in  (carry_a[NCELLS]),
        .out_ready (out_ready),
        .adv       (adv),
        .out_valid (out_valid),
        .res_out   (res)
    );

    assign hit             = res.hit;
    assign miss            = res.miss;
    assign evicted_valid   = res.ev_v;
    assign evicted_key     = res.ev_key;
    assign miss_total      = res.miss_total;
    assign reference_total = res.ref_total;
    assign error           = res.err;
    assign done_res        = res.done;

endmodule

`default_nettype wire

// File: tb/tb_lru_cache_miss_counter.sv
`timescale 1ns / 1ps

// Checks the LRU cache miss counter against a shadow cache kept in this bench.
// The shadow holds a doubly linked recency list, a residency bit per key and the
// two running totals. Each input beat is turned into one outcome when it is
// accepted. The outcome queues up and is compared field by field with the next
// result beat. Registers change only while nothing is outstanding.
module tb_lru_cache_miss_counter;
    import lcmc_pkg::*;

    localparam int KEYS          = 1024;
    localparam int CYCLE_LIMIT   = 1000000;
    // The cell chain may be as long as the key space, so wait it out at the end.
    localparam int SETTLE_CYCLES = 2 * CAP_LIMIT + 16;
    localparam int RANDOM_REFS   = 1500;
    // Index with no register behind it; a write there must change nothing.
    localparam logic [CFGI_W-1:0] REG_UNUSED = 2'd3;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;

    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [CFGI_W-1:0]  cfg_index  = '0;
    logic [CFG_W-1:0]   cfg_data   = '0;

    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [BLK_W-1:0]   block      = '0;
    logic [TILE_W-1:0]  tile       = '0;
    logic               active     = 1'b0;
    logic               final_item = 1'b0;

    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic               hit;
    logic               miss;
    logic               evicted_valid;
    logic [EVK_W-1:0]   evicted_key;
    logic [CNT_W-1:0]   miss_total;
    logic [CNT_W-1:0]   reference_total;
    logic               error;
    logic               done_res;

    lru_cache_miss_counter dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .block           (block),
        .tile            (tile),
        .active          (active),
        .final_item      (final_item),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .hit             (hit),
        .miss            (miss),
        .evicted_valid   (evicted_valid),
        .evicted_key     (evicted_key),
        .miss_total      (miss_total),
        .reference_total (reference_total),
        .error           (error),
        .done_res        (done_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow cache: register copies, recency list and totals
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   cap_reg    = CAPACITY_RST;
    logic [CFG_W-1:0]   tiles_reg  = TILES_RST;
    logic [CFG_W-1:0]   blocks_reg = BLOCKS_RST;

    bit                 is_resident [KEYS];
    int unsigned        older_key   [KEYS];
    int unsigned        newer_key   [KEYS];
    int unsigned        lru_key;
    int unsigned        mru_key;
    int unsigned        held_keys;
    logic [CNT_W-1:0]   miss_sum;
    logic [CNT_W-1:0]   ref_sum;

    // Outcomes of accepted references still waiting for their result beat.
    res_t               lookup_outcomes [$];
    res_t               last_outcome;

    int                 fail_count = 0;
    // Clear to run both channels at full rate.
    bit                 pacing     = 1'b0;

    // End of stream empties the cache and zeroes both totals; registers stay.
    function automatic void clear_cache();
        for (int k = 0; k < KEYS; k++)
            is_resident[k] = 1'b0;
        lru_key   = 0;
        mru_key   = 0;
        held_keys = 0;
        miss_sum  = '0;
        ref_sum   = '0;
    endfunction

    // Link a key in as most recent; an empty list makes it the LRU end too.
    function automatic void push_mru(input int unsigned k);
        if (held_keys == 0)
            lru_key = k;
        else
            newer_key[mru_key % KEYS] = k;
        older_key[k] = mru_key;
        mru_key      = k;
        held_keys++;
    endfunction

    // Apply one reference to the shadow cache and return the beat it must produce.
    function automatic res_t cache_access(input logic [BLK_W-1:0] b, input logic [TILE_W-1:0] t,
                                          input logic a, input logic f);
        res_t        r;
        int unsigned span;
        int unsigned k;
        int unsigned nw;
        int unsigned od;
        int unsigned victim;

        r      = '0;
        span   = 32'(tiles_reg) * 32'(blocks_reg);
        r.done = f;
        // A register at zero or a key space past the table blocks every item.
        if (cap_reg == 0 || tiles_reg == 0 || blocks_reg == 0 || span > KEYS)
            r.err = 1'b1;
        else if (a)
        begin
            k = 32'(b) * 32'(tiles_reg) + 32'(t);
            if (k >= span)
                r.err = 1'b1;
            else
            begin
                if (ref_sum != CNT_MAX)
                    ref_sum++;
                if (is_resident[k])
                begin
                    r.hit = 1'b1;
                    // Unlink and move to the MRU end unless it is already there.
                    if (k != mru_key)
                    begin
                        nw = newer_key[k] % KEYS;
                        if (k == lru_key)
                            lru_key = nw;
                        else
                        begin
                            od            = older_key[k] % KEYS;
                            newer_key[od] = nw;
                            older_key[nw] = od;
                        end
                        held_keys--;
                        push_mru(k);
                    end
                end
                else
                begin
                    r.miss = 1'b1;
                    if (miss_sum != CNT_MAX)
                        miss_sum++;
                    // One eviction per miss, even when capacity has dropped further.
                    if (held_keys >= cap_reg && held_keys > 0)
                    begin
                        victim = lru_key % KEYS;
                        if (held_keys > 1)
                            lru_key = newer_key[victim] % KEYS;
                        is_resident[victim] = 1'b0;
                        held_keys--;
                        r.ev_v   = 1'b1;
                        r.ev_key = victim[EVK_W-1:0];
                    end
                    is_resident[k] = 1'b1;
                    push_mru(k);
                end
            end
        end
        r.miss_total = miss_sum;
        r.ref_total  = ref_sum;
        if (f)
            clear_cache();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Pacing: mostly back to back or short gaps, now and then a long one
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!pacing || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Result side back-pressure: drop ready for a random stretch, then hold it high.
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (pacing && stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (pacing && $urandom_range(0, 2) == 0)
                stall_left <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest outstanding outcome
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                        input logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lookup_outcomes.size() == 0)
            begin
                $display("%0t: result beat with no reference outstanding", $time);
                fail_count++;
            end
            else
            begin
                want = lookup_outcomes.pop_front();
                check_field("hit", want.hit, hit);
                check_field("miss", want.miss, miss);
                check_field("evicted_valid", want.ev_v, evicted_valid);
                check_field("evicted_key", want.ev_key, evicted_key);
                check_field("miss_total", want.miss_total, miss_total);
                check_field("reference_total", want.ref_total, reference_total);
                check_field("error", want.err, error);
                check_field("done_res", want.done, done_res);
            end
        end
    end

    // Hard stop in case the block hangs.
    int unsigned cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lru_cache_miss_counter verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Channel drivers; all are entered right after a rising edge
    // ------------------------------------------------------------------

    // Send one reference beat. Valid is left high on return so that a following
    // beat with no gap keeps it up without a drop in between.
    task automatic send_ref(input logic [BLK_W-1:0] b, input logic [TILE_W-1:0] t,
                            input logic a, input logic f);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        block      <= b;
        tile       <= t;
        active     <= a;
        final_item <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_outcome = cache_access(b, t, a, f);
        lookup_outcomes.push_back(last_outcome);
    endtask

    // Drop input valid and hold until every outstanding result beat has arrived.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (lookup_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // One register write beat; valid stays high for a following write.
    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CAPACITY: cap_reg    = val;
            REG_TILES:    tiles_reg  = val;
            REG_BLOCKS:   blocks_reg = val;
            default:      ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] cap, input logic [CFG_W-1:0] tpb,
                              input logic [CFG_W-1:0] bc);
        write_reg(REG_CAPACITY, cap);
        write_reg(REG_TILES, tpb);
        write_reg(REG_BLOCKS, bc);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers give a key space of one key: only block 0, tile 0 is legal.
    task automatic test_reset_defaults();
        pacing = 1'b0;
        send_ref(10'd0, 10'd0, 1'b1, 1'b0);        // cold miss
        send_ref(10'd0, 10'd0, 1'b1, 1'b0);        // hit on the only key
        send_ref(10'd1, 10'd0, 1'b1, 1'b0);        // key past the key space
        send_ref(10'd1023, 10'd1023, 1'b0, 1'b0);  // skipped reference
        send_ref(10'd0, 10'd0, 1'b1, 1'b1);        // end of stream with totals
        wait_quiet();
    endtask

    // Walk the recency list: hit at the MRU end, in the middle and at the LRU end,
    // then a miss that must evict the right key.
    task automatic test_lru_order();
        pacing = 1'b1;
        set_config(11'd3, 11'd8, 11'd8);
        send_ref(10'd0, 10'd5, 1'b1, 1'b0);        // key 5
        send_ref(10'd1, 10'd1, 1'b1, 1'b0);        // key 9
        send_ref(10'd7, 10'd7, 1'b1, 1'b0);        // key 63, list 5 9 63
        send_ref(10'd7, 10'd7, 1'b1, 1'b0);        // MRU hit, no move
        send_ref(10'd1, 10'd1, 1'b1, 1'b0);        // middle hit, list 5 63 9
        send_ref(10'd0, 10'd5, 1'b1, 1'b0);        // LRU hit, list 63 9 5
        send_ref(10'd2, 10'd4, 1'b1, 1'b0);        // key 20 evicts 63
        send_ref(10'd0, 10'd0, 1'b0, 1'b1);        // end of stream on a skipped item
        wait_quiet();
    endtask

    // Fill, then drop capacity below occupancy: each miss evicts just one key.
    task automatic test_capacity_shrink();
        pacing = 1'b1;
        set_config(11'd8, 11'd16, 11'd4);
        send_ref(10'd0, 10'd1, 1'b1, 1'b0);
        send_ref(10'd0, 10'd2, 1'b1, 1'b0);
        send_ref(10'd1, 10'd0, 1'b1, 1'b0);
        send_ref(10'd3, 10'd15, 1'b1, 1'b0);
        wait_quiet();
        write_reg(REG_CAPACITY, 11'd1);
        cfg_valid <= 1'b0;
        send_ref(10'd2, 10'd0, 1'b1, 1'b0);        // evicts key 1, still four held
        send_ref(10'd2, 10'd1, 1'b1, 1'b0);        // evicts key 2
        send_ref(10'd2, 10'd1, 1'b1, 1'b1);
        wait_quiet();
    endtask

    // Each way the configuration can be illegal blocks every item, skipped ones too.
    task automatic test_bad_config();
        pacing = 1'b0;
        set_config(11'd0, 11'd4, 11'd4);
        send_ref(10'd0, 10'd1, 1'b1, 1'b0);
        wait_quiet();
        write_reg(REG_CAPACITY, 11'd4);
        write_reg(REG_TILES, 11'd0);
        cfg_valid <= 1'b0;
        send_ref(10'd0, 10'd1, 1'b1, 1'b0);
        wait_quiet();
        write_reg(REG_TILES, 11'd33);
        write_reg(REG_BLOCKS, 11'd0);
        cfg_valid <= 1'b0;
        send_ref(10'd0, 10'd0, 1'b0, 1'b0);
        wait_quiet();
        // 33 x 32 overruns the table; the spare index must leave registers alone.
        write_reg(REG_BLOCKS, 11'd32);
        write_reg(REG_UNUSED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
        send_ref(10'd3, 10'd5, 1'b1, 1'b0);
        wait_quiet();
    endtask

    // Largest block and tile indexes, largest capacity, and a key reached two ways.
    task automatic test_field_extremes();
        pacing = 1'b1;
        set_config(CFG_W'(CAP_LIMIT), 11'd1, 11'd1024);
        send_ref(10'd1023, 10'd0, 1'b1, 1'b0);     // key 1023
        send_ref(10'd0, 10'd0, 1'b1, 1'b0);        // key 0
        wait_quiet();
        write_reg(REG_TILES, 11'd1024);
        write_reg(REG_BLOCKS, 11'd1);
        cfg_valid <= 1'b0;
        send_ref(10'd0, 10'd1023, 1'b1, 1'b0);     // key 1023 again, now a hit
        send_ref(10'd1, 10'd0, 1'b1, 1'b0);        // block past block count
        send_ref(10'd0, 10'd0, 1'b1, 1'b1);
        wait_quiet();
    endtask

    // Phases of random settings. Most references come from a small working set so
    // that hits, reorders and evictions are frequent; the rest are random keys,
    // skipped items and raw field noise. State carries across phases unless a
    // stream ended, which exercises capacity drops on a warm cache.
    task automatic test_random_streams();
        int          refs_done;
        int          phase;
        int          items;
        int          pool_n;
        int          span;
        int          roll;
        int          key;
        int          cap_v;
        int          tpb_v;
        int          bc_v;
        logic        fin;
        int unsigned key_pool [$];

        refs_done = 0;
        phase     = 0;
        while (refs_done < RANDOM_REFS)
        begin
            pacing = (phase % 4 != 3);
            case ($urandom_range(0, 5))
                0:       cap_v = 1;
                1:       cap_v = 2;
                2:       cap_v = $urandom_range(1, 16);
                3:       cap_v = $urandom_range(17, 64);
                4:       cap_v = 1024;
                default: cap_v = CAP_LIMIT;
            endcase
            case ($urandom_range(0, 3))
                0:
                begin
                    tpb_v = $urandom_range(1, 32);
                    bc_v  = $urandom_range(1, 1024 / tpb_v);
                end
                1:
                begin
                    tpb_v = 1;
                    bc_v  = 1024;
                end
                2:
                begin
                    tpb_v = 1024;
                    bc_v  = 1;
                end
                default:
                begin
                    tpb_v = $urandom_range(1, 8);
                    bc_v  = $urandom_range(1, 8);
                end
            endcase
            set_config(CFG_W'(cap_v), CFG_W'(tpb_v), CFG_W'(bc_v));

            span = tpb_v * bc_v;
            key_pool.delete();
            pool_n = $urandom_range(1, (span < 48) ? span : 48);
            repeat (pool_n)
                key_pool.push_back($urandom_range(0, span - 1));

            items = $urandom_range(60, 200);
            repeat (items)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 80)
                    key = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    key = $urandom_range(0, span - 1);
                fin = ($urandom_range(0, 79) == 0);
                if (roll < 88)
                    send_ref(BLK_W'(key / tpb_v), TILE_W'(key % tpb_v), 1'b1, fin);
                else if (roll < 94)
                    send_ref(BLK_W'($urandom), TILE_W'($urandom), 1'b0, fin);
                else
                    send_ref(BLK_W'($urandom), TILE_W'($urandom), 1'b1, fin);
                if (last_outcome.hit || last_outcome.miss)
                    refs_done++;
            end
            wait_quiet();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_cache();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_lru_order();
        test_capacity_shrink();
        test_bad_config();
        test_field_extremes();
        test_random_streams();

        // Let any stray beat surface before the verdict.
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("lru_cache_miss_counter verification clean");
        else
            $display("lru_cache_miss_counter verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/lcmc_pkg.sv
sv/lcmc_front.sv
sv/lcmc_cell.sv
sv/lcmc_back.sv
sv/lru_cache_miss_counter.sv
tb/tb_lru_cache_miss_counter.sv
